[rtl/kti_pkg.sv]
// Shared constants, types and helpers for the keyframe track interpolator.
package kti_pkg;

	localparam int MAX_KEYS = 64;
	localparam int TRACKS   = 2;
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);
	localparam int TRK_W    = $clog2(TRACKS);
	localparam int ADDR_W   = TRK_W + IDX_W;
	// rows are addressed as {track, index}, so each track owns a power-of-two slot range
	localparam int DEPTH    = TRACKS * (2 ** IDX_W);

	localparam int FRAME_W  = 16;
	localparam int VAL_W    = 32;
	localparam int TIME_W   = 24;
	localparam int NUM_W    = 32;
	localparam int QUO_W    = 16;
	localparam int STEP_W   = $clog2(QUO_W + 1);

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [FRAME_W-1:0]      frame;
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] y;
		logic signed [VAL_W-1:0] z;
	} key_t;

	// divider handshake toward the sequencer
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_stat_t;

	function automatic logic signed [VAL_W-1:0] key_comp(input key_t k, input logic [1:0] c);
		logic signed [VAL_W-1:0] v;
		unique case (c)
			2'd0:    v = k.x;
			2'd1:    v = k.y;
			default: v = k.z;
		endcase
		return v;
	endfunction

endpackage

[rtl/keyframe_track_interpolator.sv]
// Top level: two keyframe tracks with a sequencer, shared divider and one multiplier.
//
// Input channel (in_valid/in_ready) takes one word per item: operation selects
// append (store key_frame/key_x/key_y/key_z at the end of the track) or sample
// (evaluate the track at sample_time, unsigned Q16.8). Every item returns one
// word on the output channel (out_valid/out_ready): out_x/out_y/out_z and status.
// in_ready is high only while the sequencer is idle; one item is in work at a time.
// Append, empty track: the item goes straight to S_DONE, which loads the output. Sample:
// keys are scanned one by one from the key memory, through S_LOAD and S_CHECK per key
// (registered read), until a key ends the scan.
// An interpolation then fetches the earlier key (S_PLOAD, S_PCAP), runs the 16-step
// serial divide of the fraction and makes three sub/multiply/add passes through the
// single multiplier. The sequencer is back in idle, ready for the next item, in the
// cycle in which out_valid rises.
// Reset clears both key counts, so tracks start empty; the memory is not cleared
// and is only read below the count. A finished result waits in the output
// register while the receiver stalls; the sequencer holds its next result until
// the output register frees, and takes a new item once back to idle.
module keyframe_track_interpolator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic                                track,
	input  logic [kti_pkg::FRAME_W-1:0]         key_frame,
	input  logic signed [kti_pkg::VAL_W-1:0]    key_x,
	input  logic signed [kti_pkg::VAL_W-1:0]    key_y,
	input  logic signed [kti_pkg::VAL_W-1:0]    key_z,
	input  logic [kti_pkg::TIME_W-1:0]          sample_time,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [kti_pkg::VAL_W-1:0]    out_x,
	output logic signed [kti_pkg::VAL_W-1:0]    out_y,
	output logic signed [kti_pkg::VAL_W-1:0]    out_z,
	output logic [1:0]                          status
);

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_CHECK, S_PLOAD, S_PCAP, S_DIV, S_SUB, S_MUL, S_ADD, S_DONE
	} state_t;

	state_t                             state_q;
	logic [kti_pkg::CNT_W-1:0]          count_q [kti_pkg::TRACKS];
	logic [kti_pkg::TRK_W-1:0]          trk_q;
	logic [kti_pkg::IDX_W-1:0]          idx_q;
	logic [kti_pkg::TIME_W-1:0]         time_q;
	kti_pkg::key_t                      cur_q;
	kti_pkg::key_t                      prev_q;
	logic [kti_pkg::QUO_W-1:0]          frac_q;
	logic [1:0]                         comp_q;
	logic signed [kti_pkg::VAL_W:0]     diff_q;
	logic signed [kti_pkg::VAL_W+kti_pkg::QUO_W+1:0] prod_q;
	logic signed [kti_pkg::VAL_W-1:0]   res_q [3];
	logic [1:0]                         rstat_q;
	logic                               out_valid_q;
	logic signed [kti_pkg::VAL_W-1:0]   out_x_q;
	logic signed [kti_pkg::VAL_W-1:0]   out_y_q;
	logic signed [kti_pkg::VAL_W-1:0]   out_z_q;
	logic [1:0]                         status_q;

	logic                               accept;
	logic [kti_pkg::CNT_W-1:0]          cnt_sel;
	logic                               full;
	logic                               wr_en;
	kti_pkg::key_t                      wkey;
	kti_pkg::key_t                      rkey;
	logic [kti_pkg::ADDR_W-1:0]         waddr;
	logic [kti_pkg::ADDR_W-1:0]         raddr;
	logic [kti_pkg::TIME_W-1:0]         fq;
	logic                               is_last;
	logic                               div_start;
	logic [kti_pkg::NUM_W-1:0]          div_num;
	logic [kti_pkg::FRAME_W-1:0]        div_den;
	logic [kti_pkg::TIME_W-1:0]         t_off;
	kti_pkg::div_stat_t                 div_stat;
	logic signed [kti_pkg::VAL_W-1:0]   sum;
	logic                               out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign cnt_sel  = count_q[track];
	assign full     = (cnt_sel == kti_pkg::CNT_W'(kti_pkg::MAX_KEYS));
	assign wr_en    = accept && (operation == kti_pkg::OP_APPEND) && !full;
	assign waddr    = {track, cnt_sel[kti_pkg::IDX_W-1:0]};
	assign raddr    = {trk_q, idx_q};

	assign wkey.frame = key_frame;
	assign wkey.x     = key_x;
	assign wkey.y     = key_y;
	assign wkey.z     = key_z;

	kti_store u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wkey  (wkey),
		.raddr (raddr),
		.rkey  (rkey)
	);

	assign fq      = {rkey.frame, 8'h00};
	assign is_last = ({1'b0, idx_q} + 1'b1) == count_q[trk_q];

	// prev key lies strictly before t, so the offset is positive
	assign t_off     = time_q - {rkey.frame, 8'h00};
	assign div_num   = {t_off, 8'h00};
	assign div_den   = cur_q.frame - rkey.frame;
	assign div_start = (state_q == S_PCAP);

	kti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat)
	);

	// floor(d*a/65536) is the arithmetic shift; only the low word of the sum matters
	assign sum      = kti_pkg::key_comp(prev_q, comp_q)
		+ prod_q[kti_pkg::VAL_W+kti_pkg::QUO_W-1:kti_pkg::QUO_W];
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q[0]  <= '0;
			count_q[1]  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in S_DONE the output register is reloaded below instead
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				count_q[track] <= cnt_sel + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						trk_q  <= track;
						time_q <= sample_time;
						idx_q  <= '0;
						res_q[0] <= '0;
						res_q[1] <= '0;
						res_q[2] <= '0;
						if (operation == kti_pkg::OP_APPEND) begin
							rstat_q <= full ? kti_pkg::ST_FULL : kti_pkg::ST_OK;
							state_q <= S_DONE;
						end else if (cnt_sel == '0) begin
							rstat_q <= kti_pkg::ST_EMPTY;
							state_q <= S_DONE;
						end else begin
							rstat_q <= kti_pkg::ST_OK;
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: state_q <= S_CHECK;
				S_CHECK: begin
					cur_q <= rkey;
					if (fq == time_q || (fq > time_q && idx_q == '0) ||
					    (fq < time_q && is_last)) begin
						res_q[0] <= rkey.x;
						res_q[1] <= rkey.y;
						res_q[2] <= rkey.z;
						state_q  <= S_DONE;
					end else if (fq > time_q) begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_PLOAD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_PLOAD: state_q <= S_PCAP;
				S_PCAP: begin
					prev_q  <= rkey;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						frac_q  <= div_stat.quo;
						comp_q  <= 2'd0;
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					diff_q  <= (kti_pkg::VAL_W+1)'(kti_pkg::key_comp(cur_q, comp_q))
						- (kti_pkg::VAL_W+1)'(kti_pkg::key_comp(prev_q, comp_q));
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= diff_q * $signed({1'b0, frac_q});
					state_q <= S_ADD;
				end
				S_ADD: begin
					res_q[comp_q] <= sum;
					if (comp_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= S_SUB;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_x_q     <= res_q[0];
						out_y_q     <= res_q[1];
						out_z_q     <= res_q[2];
						status_q    <= rstat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign status    = status_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == kti_pkg::OP_APPEND && !full)
		|=> count_q[$past(track)] == $past(cnt_sel) + 1'b1)
		else $error("key count did not advance on append");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= kti_pkg::CNT_W'(kti_pkg::MAX_KEYS) &&
		count_q[1] <= kti_pkg::CNT_W'(kti_pkg::MAX_KEYS))
		else $error("key count beyond capacity");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.done || div_stat.busy) |-> state_q == S_DIV)
		else $error("divider active outside divide step");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == kti_pkg::ST_FULL || status == kti_pkg::ST_EMPTY))
		|-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("nonzero word on dropped append or empty track");

endmodule

[rtl/kti_div.sv]
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W bits.
module kti_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [kti_pkg::NUM_W-1:0]    num,
	input  logic [kti_pkg::FRAME_W-1:0]  den,
	output kti_pkg::div_stat_t           stat
);

	logic [kti_pkg::FRAME_W-1:0] rem_q;
	logic [kti_pkg::QUO_W-1:0]   qsh_q;
	logic [kti_pkg::STEP_W-1:0]  cnt_q;
	logic                        done_q;
	logic [kti_pkg::FRAME_W:0]   trial;
	logic [kti_pkg::FRAME_W:0]   diff;
	logic                        fits;

	assign trial = {rem_q, qsh_q[kti_pkg::QUO_W-1]};
	assign diff  = trial - {1'b0, den};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == kti_pkg::STEP_W'(1));
			if (start) begin
				cnt_q <= kti_pkg::STEP_W'(kti_pkg::QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// high half is below den, so it seeds the remainder directly
			rem_q <= num[kti_pkg::NUM_W-1 -: kti_pkg::FRAME_W];
			qsh_q <= num[kti_pkg::QUO_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[kti_pkg::FRAME_W-1:0] : trial[kti_pkg::FRAME_W-1:0];
			qsh_q <= {qsh_q[kti_pkg::QUO_W-2:0], fits};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign stat.quo  = qsh_q;

endmodule

[rtl/kti_store.sv]
// Key memory: one row per key (frame and three components), registered read.
module kti_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [kti_pkg::ADDR_W-1:0] waddr,
	input  kti_pkg::key_t              wkey,
	input  logic [kti_pkg::ADDR_W-1:0] raddr,
	output kti_pkg::key_t              rkey
);

	kti_pkg::key_t mem [kti_pkg::DEPTH];
	kti_pkg::key_t rkey_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wkey;
		end
		rkey_q <= mem[raddr];
	end

	assign rkey = rkey_q;

endmodule
